// ===== sv/idsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_pkg
// Types and constants shared by the duration parser: transaction structs,
// parse phases, character codes and field widths.
// ----------------------------------------------------------------------------
package idsp_pkg;

	localparam int NUMBER_BITS = 32;
	localparam int FRAC_DIGITS = 9;
	localparam int TOTAL_BITS  = 48;
	localparam int FRAC_BITS   = 30;
	localparam int COUNT_BITS  = 4;

	localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = '1;
	localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;

	localparam logic [8:0] DAYS_PER_YEAR  = 9'd360;
	localparam logic [8:0] DAYS_PER_MONTH = 9'd30;
	localparam logic [8:0] DAYS_PER_WEEK  = 9'd7;
	localparam logic [8:0] DAYS_PER_DAY   = 9'd1;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_S     = 8'h53;

	typedef enum logic [3:0] {
		PH_WAIT_P  = 4'd0,
		PH_AFTER_P = 4'd1,
		PH_YEAR    = 4'd2,
		PH_MONTH   = 4'd3,
		PH_WEEK    = 4'd4,
		PH_DAY     = 4'd5,
		PH_TIME    = 4'd6,
		PH_HOUR    = 4'd7,
		PH_MINUTE  = 4'd8,
		PH_POINT   = 4'd9,
		PH_SECOND  = 4'd10
	} idsp_phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} idsp_item_t;

	typedef struct packed {
		logic                  format_ok;
		logic [TOTAL_BITS-1:0] total_seconds;
		logic [FRAC_BITS-1:0]  fraction_nanoseconds;
		logic                  saturated;
	} idsp_result_t;

	typedef struct packed {
		logic                   ok;
		logic [TOTAL_BITS-1:0]  day;
		logic [NUMBER_BITS-1:0] hour;
		logic [NUMBER_BITS-1:0] minute;
		logic [NUMBER_BITS-1:0] second;
		logic [FRAC_BITS-1:0]   frac;
		logic [COUNT_BITS-1:0]  fcount;
		logic                   frac_done;
		logic                   ovf;
	} idsp_snap_t;

endpackage

// ===== sv/idsp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_parser
// Character state machine: accumulates numbers, checks designator order and
// folds Y, M, W and D into a day count. On the final character it presents
// a snapshot of the parsed fields and returns to its reset state.
// ----------------------------------------------------------------------------
module idsp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  idsp_pkg::idsp_item_t   ch,
	output idsp_pkg::idsp_snap_t   snap
);
	import idsp_pkg::*;

	localparam int ACC_EXT_W  = NUMBER_BITS + 4;
	localparam int PROD_W     = NUMBER_BITS + 9;
	localparam int DAY_SUM_W  = TOTAL_BITS + 1;
	localparam int FRAC_EXT_W = FRAC_BITS + 4;

	idsp_phase_t            phase_q, n_phase;
	logic [NUMBER_BITS-1:0] accum_q, n_accum;
	logic [TOTAL_BITS-1:0]  day_q, n_day;
	logic [NUMBER_BITS-1:0] hour_q, n_hour;
	logic [NUMBER_BITS-1:0] minute_q, n_minute;
	logic [NUMBER_BITS-1:0] second_q, n_second;
	logic [FRAC_BITS-1:0]   frac_q, n_frac;
	logic [COUNT_BITS-1:0]  fcount_q, n_fcount;
	logic                   failed_q, n_failed;
	logic                   ovf_q, n_ovf;

	logic                   do_days;
	logic [8:0]             day_factor;
	logic [3:0]             digit;
	logic [ACC_EXT_W-1:0]   acc_ext;
	logic [FRAC_EXT_W-1:0]  frac_ext;
	logic [PROD_W-1:0]      day_prod;
	logic [DAY_SUM_W-1:0]   day_sum;

	assign digit    = ch.char_code[3:0];
	assign acc_ext  = ACC_EXT_W'(accum_q) * ACC_EXT_W'(10) + ACC_EXT_W'(digit);
	assign frac_ext = FRAC_EXT_W'(frac_q) * FRAC_EXT_W'(10) + FRAC_EXT_W'(digit);
	assign day_prod = PROD_W'(accum_q) * PROD_W'(day_factor);
	assign day_sum  = {1'b0, day_q} + DAY_SUM_W'(day_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_P;
			accum_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			fcount_q <= '0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (take) begin
			if (ch.last_char) begin
				phase_q  <= PH_WAIT_P;
				accum_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				frac_q   <= '0;
				fcount_q <= '0;
				failed_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else begin
				phase_q  <= n_phase;
				accum_q  <= n_accum;
				day_q    <= n_day;
				hour_q   <= n_hour;
				minute_q <= n_minute;
				second_q <= n_second;
				frac_q   <= n_frac;
				fcount_q <= n_fcount;
				failed_q <= n_failed;
				ovf_q    <= n_ovf;
			end
		end
	end

	always_comb begin
		n_phase    = phase_q;
		n_accum    = accum_q;
		n_day      = day_q;
		n_hour     = hour_q;
		n_minute   = minute_q;
		n_second   = second_q;
		n_frac     = frac_q;
		n_fcount   = fcount_q;
		n_failed   = failed_q;
		n_ovf      = ovf_q;
		do_days    = 1'b0;
		day_factor = DAYS_PER_DAY;

		if (!failed_q) begin
			if (phase_q == PH_WAIT_P) begin
				if (ch.char_code == CH_P)
					n_phase = PH_AFTER_P;
				else
					n_failed = 1'b1;
			end else if (ch.char_code >= CH_ZERO && ch.char_code <= CH_NINE) begin
				if (phase_q == PH_POINT) begin
					if (fcount_q < COUNT_BITS'(FRAC_DIGITS)) begin
						n_frac   = frac_ext[FRAC_BITS-1:0];
						n_fcount = fcount_q + 1'b1;
					end
				end else if (acc_ext > ACC_EXT_W'(NUMBER_MAX)) begin
					n_accum = NUMBER_MAX;
					n_ovf   = 1'b1;
				end else begin
					n_accum = acc_ext[NUMBER_BITS-1:0];
				end
			end else begin
				case (ch.char_code)
					CH_Y: begin
						if (phase_q == PH_AFTER_P) begin
							do_days    = 1'b1;
							day_factor = DAYS_PER_YEAR;
							n_phase    = PH_YEAR;
						end else
							n_failed = 1'b1;
					end
					CH_M: begin
						if (phase_q inside {PH_AFTER_P, PH_YEAR}) begin
							do_days    = 1'b1;
							day_factor = DAYS_PER_MONTH;
							n_phase    = PH_MONTH;
						end else if (phase_q inside {PH_TIME, PH_HOUR}) begin
							n_minute = accum_q;
							n_accum  = '0;
							n_phase  = PH_MINUTE;
						end else
							n_failed = 1'b1;
					end
					CH_W: begin
						if (phase_q inside {PH_AFTER_P, PH_YEAR, PH_MONTH}) begin
							do_days    = 1'b1;
							day_factor = DAYS_PER_WEEK;
							n_phase    = PH_WEEK;
						end else
							n_failed = 1'b1;
					end
					CH_D: begin
						if (phase_q inside {PH_AFTER_P, PH_YEAR, PH_MONTH, PH_WEEK}) begin
							do_days    = 1'b1;
							day_factor = DAYS_PER_DAY;
							n_phase    = PH_DAY;
						end else
							n_failed = 1'b1;
					end
					CH_T: begin
						if (phase_q inside {PH_AFTER_P, PH_YEAR, PH_MONTH, PH_WEEK, PH_DAY})
							n_phase = PH_TIME;
						else
							n_failed = 1'b1;
					end
					CH_H: begin
						if (phase_q == PH_TIME) begin
							n_hour  = accum_q;
							n_accum = '0;
							n_phase = PH_HOUR;
						end else
							n_failed = 1'b1;
					end
					CH_POINT: begin
						if (phase_q inside {PH_TIME, PH_HOUR, PH_MINUTE}) begin
							n_second = accum_q;
							n_accum  = '0;
							n_phase  = PH_POINT;
						end else
							n_failed = 1'b1;
					end
					CH_S: begin
						if (phase_q inside {PH_TIME, PH_HOUR, PH_MINUTE, PH_POINT}) begin
							if (phase_q != PH_POINT) begin
								n_second = accum_q;
								n_frac   = '0;
							end
							n_accum = '0;
							n_phase = PH_SECOND;
						end else
							n_failed = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end

		if (do_days) begin
			n_accum = '0;
			if (day_sum[TOTAL_BITS]) begin
				n_day = TOTAL_MAX;
				n_ovf = 1'b1;
			end else
				n_day = day_sum[TOTAL_BITS-1:0];
		end
	end

	always_comb begin
		snap.ok        = !n_failed && (n_phase != PH_WAIT_P);
		snap.day       = n_day;
		snap.hour      = n_hour;
		snap.minute    = n_minute;
		snap.second    = n_second;
		snap.frac      = n_frac;
		snap.fcount    = n_fcount;
		snap.frac_done = (n_phase == PH_SECOND);
		snap.ovf       = n_ovf;
	end

endmodule

// ===== sv/idsp_total.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_total
// Result pipeline: converts days, hours, minutes and seconds to a saturated
// 48-bit second count over three registered multiply-add stages, scales the
// fraction to nanoseconds and holds the result transaction.
// ----------------------------------------------------------------------------
module idsp_total (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_valid,
	output logic                   snap_ready,
	input  idsp_pkg::idsp_snap_t   snap,
	output logic                   result_valid,
	input  logic                   result_ready,
	output idsp_pkg::idsp_result_t result
);
	import idsp_pkg::*;

	localparam int EXT_W      = TOTAL_BITS + 6;
	localparam int FRAC_MUL_W = 2 * FRAC_BITS;

	function automatic logic [FRAC_BITS-1:0] pow_ten(input logic [COUNT_BITS-1:0] n);
		logic [FRAC_BITS-1:0] p;
		case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

	logic                   valid_s2, valid_s3, valid_s4;
	logic                   ready_s2, ready_s3, ready_s4, out_free;
	idsp_snap_t             snap_s2;

	logic                   ok_s3, ovf_s3, frac_done_s3;
	logic [TOTAL_BITS-1:0]  total_s3;
	logic [NUMBER_BITS-1:0] minute_s3, second_s3;
	logic [FRAC_BITS-1:0]   frac_s3;
	logic [COUNT_BITS-1:0]  fcount_s3;

	logic                   ok_s4, ovf_s4;
	logic [TOTAL_BITS-1:0]  total_s4;
	logic [NUMBER_BITS-1:0] second_s4;
	logic [FRAC_BITS-1:0]   frac_s4;

	logic                   result_valid_q;
	idsp_result_t           result_q;

	logic [EXT_W-1:0]       sum_s2, sum_s3, sum_s4;
	logic [COUNT_BITS-1:0]  kept_digits, scale_idx;
	logic [FRAC_MUL_W-1:0]  frac_mul;

	assign out_free   = !result_valid_q || result_ready;
	assign ready_s4   = !valid_s4 || out_free;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign snap_ready = ready_s2;

	assign sum_s2 = EXT_W'(snap_s2.day) * EXT_W'(24) + EXT_W'(snap_s2.hour);
	assign sum_s3 = EXT_W'(total_s3) * EXT_W'(60) + EXT_W'(minute_s3);
	assign sum_s4 = EXT_W'(total_s4) * EXT_W'(60) + EXT_W'(second_s4);

	assign kept_digits = (fcount_s3 > COUNT_BITS'(9)) ? COUNT_BITS'(9) : fcount_s3;
	assign scale_idx   = COUNT_BITS'(9) - kept_digits;
	assign frac_mul    = FRAC_MUL_W'(frac_s3) * FRAC_MUL_W'(pow_ten(scale_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (ready_s2)
				valid_s2 <= snap_valid;
			if (ready_s3)
				valid_s3 <= valid_s2;
			if (ready_s4)
				valid_s4 <= valid_s3;
			if (out_free)
				result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && ready_s2)
			snap_s2 <= snap;

		if (valid_s2 && ready_s3) begin
			ok_s3        <= snap_s2.ok;
			minute_s3    <= snap_s2.minute;
			second_s3    <= snap_s2.second;
			frac_s3      <= snap_s2.frac;
			fcount_s3    <= snap_s2.fcount;
			frac_done_s3 <= snap_s2.frac_done;
			if (|sum_s2[EXT_W-1:TOTAL_BITS]) begin
				total_s3 <= TOTAL_MAX;
				ovf_s3   <= 1'b1;
			end else begin
				total_s3 <= sum_s2[TOTAL_BITS-1:0];
				ovf_s3   <= snap_s2.ovf;
			end
		end

		if (valid_s3 && ready_s4) begin
			ok_s4     <= ok_s3;
			second_s4 <= second_s3;
			frac_s4   <= frac_done_s3 ? frac_mul[FRAC_BITS-1:0] : '0;
			if (|sum_s3[EXT_W-1:TOTAL_BITS]) begin
				total_s4 <= TOTAL_MAX;
				ovf_s4   <= 1'b1;
			end else begin
				total_s4 <= sum_s3[TOTAL_BITS-1:0];
				ovf_s4   <= ovf_s3;
			end
		end

		if (valid_s4 && out_free) begin
			if (!ok_s4) begin
				result_q <= '0;
			end else begin
				result_q.format_ok            <= 1'b1;
				result_q.fraction_nanoseconds <= frac_s4;
				if (|sum_s4[EXT_W-1:TOTAL_BITS]) begin
					result_q.total_seconds <= TOTAL_MAX;
					result_q.saturated     <= 1'b1;
				end else begin
					result_q.total_seconds <= sum_s4[TOTAL_BITS-1:0];
					result_q.saturated     <= ovf_s4;
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/iso_duration_to_seconds_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_duration_to_seconds_parser_top
// ISO 8601 duration parser: one character per transaction in, one result
// transaction per string out, on the character marked last.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+-------------------------------
//   item    | item_valid   | item_ready   | item   (char_code, last_char)
//   result  | result_valid | result_ready | result (format_ok, seconds,
//           |              |              |         nanoseconds, saturated)
//
// One character is accepted every cycle unless a final character waits in the
// input register for room in the result stages; parse state is registered
// from it. A result passes the input and snapshot registers and the day/hour,
// minute and second multiply-add stages before it is presented. Reset clears
// all control and parse state, which also returns to reset after each final
// character. Holding result_ready low fills the stages; final characters wait.
// ----------------------------------------------------------------------------
module iso_duration_to_seconds_parser_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  idsp_pkg::idsp_item_t   item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output idsp_pkg::idsp_result_t result
);
	import idsp_pkg::*;

	logic        valid_s1;
	idsp_item_t  item_s1;
	logic        take;
	logic        snap_ready;
	idsp_snap_t  snap;

	assign take       = valid_s1 && (!item_s1.last_char || snap_ready);
	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	idsp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (item_s1),
		.snap   (snap)
	);

	idsp_total u_total (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (take && item_s1.last_char),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== sv/idsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_checker
// Port-level checks on the duration parser's item and result channels, bound
// to the top level.
// ----------------------------------------------------------------------------
module idsp_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_ready,
	input idsp_pkg::idsp_item_t   item,
	input logic                   result_valid,
	input logic                   result_ready,
	input idsp_pkg::idsp_result_t result
);
	import idsp_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.format_ok |->
			result.total_seconds == '0 && result.fraction_nanoseconds == '0 &&
			!result.saturated)
		else $error("format error result carries non-zero fields");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.fraction_nanoseconds <= 30'd999999999)
		else $error("nanoseconds out of range");

	a_mid_char_flow: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item.last_char |=> item_ready)
		else $error("item channel stalled after a non-final character");

endmodule

bind iso_duration_to_seconds_parser_top idsp_checker u_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ISO 8601 duration parser. Strings go in one
// character per transaction: a few fixed strings first, then random strings,
// mostly well formed with random numbers and fractions, some with noise,
// designators out of order, trailing numbers or a bad first character. A
// scoreboard class parses every accepted character the same way the block
// should and keeps the expected results, which are checked field by field as
// they leave. The sender works in bursts with gaps and the receiver stalls on
// a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;

	import idsp_pkg::*;

	localparam int unsigned TARGET_CHARS = 1850;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned NANO_DIGITS  = 9;

	class duration_scoreboard;
		idsp_result_t           expected_q[$];
		int unsigned            error_count;
		int unsigned            results_seen;
		int unsigned            invalid_seen;
		int unsigned            saturated_seen;
		idsp_phase_t            phase;
		logic [NUMBER_BITS-1:0] number_acc;
		logic [TOTAL_BITS-1:0]  days;
		logic [NUMBER_BITS-1:0] hours;
		logic [NUMBER_BITS-1:0] minutes;
		logic [NUMBER_BITS-1:0] seconds;
		logic [FRAC_BITS-1:0]   frac;
		logic [COUNT_BITS-1:0]  frac_count;
		bit                     failed;
		bit                     overflow;

		function new();
			clear();
		endfunction

		function void clear();
			phase      = PH_WAIT_P;
			number_acc = '0;
			days       = '0;
			hours      = '0;
			minutes    = '0;
			seconds    = '0;
			frac       = '0;
			frac_count = '0;
			failed     = 1'b0;
			overflow   = 1'b0;
		endfunction

		function logic [TOTAL_BITS-1:0] clamp_total(logic [63:0] x);
			if (x > 64'(TOTAL_MAX)) begin
				overflow = 1'b1;
				return TOTAL_MAX;
			end
			return x[TOTAL_BITS-1:0];
		endfunction

		function void add_days(logic [8:0] factor);
			days = clamp_total(64'(days) + 64'(number_acc) * 64'(factor));
			number_acc = '0;
		endfunction

		function void parse_char(logic [7:0] c);
			logic [63:0] n;
			logic [63:0] scaled;
			if (failed)
				return;
			if (phase == PH_WAIT_P) begin
				if (c == CH_P)
					phase = PH_AFTER_P;
				else
					failed = 1'b1;
				return;
			end
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (phase == PH_POINT) begin
					if (frac_count < FRAC_DIGITS) begin
						frac = FRAC_BITS'(64'(frac) * 10 + 64'(c - CH_ZERO));
						frac_count++;
					end
				end else begin
					n = 64'(number_acc) * 10 + 64'(c - CH_ZERO);
					if (n > 64'(NUMBER_MAX)) begin
						n = 64'(NUMBER_MAX);
						overflow = 1'b1;
					end
					number_acc = n[NUMBER_BITS-1:0];
				end
				return;
			end
			case (c)
			CH_Y: begin
				if (phase == PH_AFTER_P) begin
					add_days(DAYS_PER_YEAR);
					phase = PH_YEAR;
				end else
					failed = 1'b1;
			end
			CH_M: begin
				if (phase < PH_MONTH) begin
					add_days(DAYS_PER_MONTH);
					phase = PH_MONTH;
				end else if (phase >= PH_TIME && phase < PH_MINUTE) begin
					minutes = number_acc;
					number_acc = '0;
					phase = PH_MINUTE;
				end else
					failed = 1'b1;
			end
			CH_W: begin
				if (phase < PH_WEEK) begin
					add_days(DAYS_PER_WEEK);
					phase = PH_WEEK;
				end else
					failed = 1'b1;
			end
			CH_D: begin
				if (phase < PH_DAY) begin
					add_days(DAYS_PER_DAY);
					phase = PH_DAY;
				end else
					failed = 1'b1;
			end
			CH_T: begin
				if (phase < PH_TIME)
					phase = PH_TIME;
				else
					failed = 1'b1;
			end
			CH_H: begin
				if (phase == PH_TIME) begin
					hours = number_acc;
					number_acc = '0;
					phase = PH_HOUR;
				end else
					failed = 1'b1;
			end
			CH_POINT: begin
				if (phase >= PH_TIME && phase < PH_POINT) begin
					seconds = number_acc;
					number_acc = '0;
					phase = PH_POINT;
				end else
					failed = 1'b1;
			end
			CH_S: begin
				if (phase >= PH_TIME && phase < PH_SECOND) begin
					if (phase == PH_POINT) begin
						scaled = 64'(frac);
						for (int i = frac_count; i < NANO_DIGITS; i++)
							scaled = scaled * 10;
						frac = scaled[FRAC_BITS-1:0];
					end else begin
						seconds = number_acc;
						frac = '0;
					end
					number_acc = '0;
					phase = PH_SECOND;
				end else
					failed = 1'b1;
			end
			default: ;
			endcase
		endfunction

		function void note_char(idsp_item_t it);
			idsp_result_t want;
			logic [TOTAL_BITS-1:0] t;
			parse_char(it.char_code);
			if (!it.last_char)
				return;
			want = '0;
			if (!failed && phase != PH_WAIT_P) begin
				t = clamp_total(64'(days) * 24 + 64'(hours));
				t = clamp_total(64'(t) * 60 + 64'(minutes));
				t = clamp_total(64'(t) * 60 + 64'(seconds));
				want.format_ok            = 1'b1;
				want.total_seconds        = t;
				want.fraction_nanoseconds = (phase == PH_SECOND) ? frac : '0;
				want.saturated            = overflow;
			end
			expected_q.push_back(want);
			clear();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			error_count++;
		endtask

		task check_result(idsp_result_t got);
			idsp_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none pending: ok=%0b s=%0d ns=%0d sat=%0b",
					got.format_ok, got.total_seconds, got.fraction_nanoseconds,
					got.saturated));
				return;
			end
			want = expected_q.pop_front();
			if (!want.format_ok)
				invalid_seen++;
			if (want.saturated)
				saturated_seen++;
			if (got.format_ok !== want.format_ok)
				report($sformatf("format_ok %b, want %b", got.format_ok, want.format_ok));
			if (got.total_seconds !== want.total_seconds)
				report($sformatf("total_seconds %0d, want %0d",
					got.total_seconds, want.total_seconds));
			if (got.fraction_nanoseconds !== want.fraction_nanoseconds)
				report($sformatf("fraction_nanoseconds %0d, want %0d",
					got.fraction_nanoseconds, want.fraction_nanoseconds));
			if (got.saturated !== want.saturated)
				report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         item_valid;
	logic         item_ready;
	idsp_item_t   item;
	logic         result_valid;
	logic         result_ready;
	idsp_result_t result;

	duration_scoreboard sb;
	logic [7:0]         text_q[$];
	int unsigned        burst_left;
	int unsigned        strings_sent;
	int unsigned        chars_sent;
	int unsigned        rx_cycle;
	int unsigned        cycle_count;

	iso_duration_to_seconds_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1)
			sb.check_result(result);
		rx_cycle++;
		case ((rx_cycle / 256) % 4)
		0: result_ready <= 1'b1;
		1: result_ready <= ($urandom_range(0, 3) != 0);
		2: result_ready <= ((rx_cycle % 7) < 3);
		default: result_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_char(input logic [7:0] code, input logic last);
		idsp_item_t  tr;
		int unsigned gap;
		tr.char_code = code;
		tr.last_char = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= tr;
		do @(posedge clk); while (item_ready !== 1'b1);
		sb.note_char(tr);
		chars_sent++;
	endtask

	task automatic send_string();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		strings_sent++;
		text_q.delete();
	endtask

	task automatic hold_until_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic push_number();
		int unsigned roll;
		int unsigned digits;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			digits = 0;
		else if (roll < 70)
			digits = $urandom_range(1, 3);
		else if (roll < 90)
			digits = $urandom_range(4, 9);
		else
			digits = $urandom_range(10, 12);
		repeat (digits) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic push_fraction();
		int unsigned digits;
		digits = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
		repeat (digits) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	function automatic logic [7:0] random_mark();
		case ($urandom_range(0, 8))
		0: return CH_Y;
		1: return CH_M;
		2: return CH_W;
		3: return CH_D;
		4: return CH_T;
		5: return CH_H;
		6: return CH_POINT;
		7: return CH_S;
		default: return CH_P;
		endcase
	endfunction

	task automatic build_string();
		int unsigned kind;
		int unsigned count;
		kind = $urandom_range(0, 99);
		text_q.delete();
		if (kind >= 90) begin
			count = $urandom_range(1, 8);
			repeat (count) text_q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				text_q[0] = CH_P;
			return;
		end
		text_q.push_back(CH_P);
		if ($urandom_range(0, 1)) begin
			push_number();
			text_q.push_back(CH_Y);
		end
		if ($urandom_range(0, 1)) begin
			push_number();
			text_q.push_back(CH_M);
		end
		if ($urandom_range(0, 1)) begin
			push_number();
			text_q.push_back(CH_W);
		end
		if ($urandom_range(0, 1)) begin
			push_number();
			text_q.push_back(CH_D);
		end
		if ($urandom_range(0, 3) != 0) begin
			text_q.push_back(CH_T);
			if ($urandom_range(0, 1)) begin
				push_number();
				text_q.push_back(CH_H);
			end
			if ($urandom_range(0, 1)) begin
				push_number();
				text_q.push_back(CH_M);
			end
			if ($urandom_range(0, 1)) begin
				push_number();
				if ($urandom_range(0, 1)) begin
					text_q.push_back(CH_POINT);
					push_fraction();
				end
				text_q.push_back(CH_S);
			end
		end
		if (kind >= 60 && kind < 70) begin
			count = $urandom_range(1, 3);
			repeat (count)
				text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
		end else if (kind >= 70 && kind < 78) begin
			text_q.insert($urandom_range(1, text_q.size()), random_mark());
		end else if (kind >= 78 && kind < 85) begin
			push_number();
			if ($urandom_range(0, 1)) begin
				text_q.push_back(CH_POINT);
				push_fraction();
			end
		end else if (kind >= 85) begin
			text_q[0] = 8'($urandom_range(0, 255));
		end
	endtask

	initial begin
		sb           = new();
		burst_left   = 0;
		strings_sent = 0;
		chars_sent   = 0;
		rx_cycle     = 0;
		cycle_count  = 0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text("P1Y2M3W4DT5H6M7.25S");
		send_string();
		push_text("P");
		send_string();
		text_q.push_back(8'h00);
		send_string();
		push_text("P");
		text_q.push_back(8'hFF);
		send_string();
		hold_until_drained();

		while (chars_sent < TARGET_CHARS) begin
			build_string();
			send_string();
			if (strings_sent % 40 == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

		$display("Sent %0d strings (%0d characters), checked %0d results.",
			strings_sent, chars_sent, sb.results_seen);
		$display("Of those, %0d were format errors and %0d saturated.",
			sb.invalid_seen, sb.saturated_seen);
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== iso_duration_to_seconds_parser_top.f =====
sv/idsp_pkg.sv
sv/idsp_parser.sv
sv/idsp_total.sv
sv/iso_duration_to_seconds_parser_top.sv
sv/idsp_checker.sv
test/testbench.sv
